>>> rtl/core/rme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rme_pkg
// Shared constants, types and the arctangent table for the Euler angle block.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int CordicSteps = 16;
  localparam int SqrtSteps   = 23;
  localparam int OperW       = 34;
  localparam int AngW        = 25;
  localparam int RadW        = 45;
  localparam int Depth       = SqrtSteps + CordicSteps + 3;

  localparam logic signed [AngW-1:0] Deg180 = 25'sd5898240;
  localparam logic signed [15:0] YawLimit   = 16'sd23040;
  localparam logic signed [15:0] PitchLimit = 16'sd11520;
  localparam logic [3:0] RegLockThreshold   = 4'd0;

  typedef struct packed {
    logic signed [OperW-1:0] x;
    logic signed [OperW-1:0] y;
    logic signed [AngW-1:0]  z;
  } vec_t;

  typedef struct packed {
    logic [RadW-1:0]   rem;
    logic [RadW-1:0]   res;
    logic [RadW-1:0]   bitv;
    logic signed [15:0] sp;
  } sqrt_t;

  function automatic logic signed [AngW-1:0] atan_tab(input int i);
    logic signed [AngW-1:0] t;
    unique case (i)
      0: t = 25'sd1474560;  1: t = 25'sd870484;  2: t = 25'sd459940;
      3: t = 25'sd233473;   4: t = 25'sd117189;  5: t = 25'sd58653;
      6: t = 25'sd29333;    7: t = 25'sd14667;   8: t = 25'sd7334;
      9: t = 25'sd3667;     10: t = 25'sd1833;   11: t = 25'sd917;
      12: t = 25'sd458;     13: t = 25'sd229;    14: t = 25'sd115;
      15: t = 25'sd57;      16: t = 25'sd29;     17: t = 25'sd14;
      18: t = 25'sd7;       19: t = 25'sd4;      20: t = 25'sd2;
      21: t = 25'sd1;       default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic signed [15:0] to_out(input logic signed [AngW-1:0] z,
                                                input logic signed [15:0] lim);
    logic signed [AngW:0] a;
    a = (26'(z) + 26'sd128) >>> 8;
    if (a > 26'(lim)) return lim;
    if (a < -26'(lim)) return -lim;
    return a[15:0];
  endfunction

  function automatic vec_t pre_rot(input logic signed [OperW-1:0] y,
                                   input logic signed [OperW-1:0] x);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = '0;
    if (x < 0) begin
      v.z = (y >= 0) ? Deg180 : -Deg180;
      v.x = -x;
      v.y = -y;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rotation_matrix_to_euler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_top
// Rotation matrix to pitch, yaw and roll.
// ----------------------------------------------------------------------------
// One item enters per cycle while the output is not stalled, and its result is
// registered through 23 square root cells for the cosine of pitch, a pre-rotation
// stage, 16 CORDIC steps with one cell per step in each of three angle lanes, and an output
// stage. The whole pipeline advances whenever the output register is empty or
// being taken, so a stalled output holds the input as well.
module rotation_matrix_to_euler_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c2 from bit 0 up
  input  wire logic [111:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // pitch[14:0], yaw[30:15], roll[46:31], pad
  output logic [47:0]      m_tdata,
  // gimbal_lock
  output logic             m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int SS = rme_pkg::SqrtSteps;
  localparam int CS = rme_pkg::CordicSteps;
  localparam int L  = SS + CS + 2;

  logic [14:0] lock_threshold;
  logic [L-1:0] vld;
  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'(rme_pkg::RegLockThreshold)) ?
                  {17'd0, lock_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_threshold <= 15'd16;
    end else if (psel && penable && pwrite && paddr == 2'(rme_pkg::RegLockThreshold)) begin
      lock_threshold <= pwdata[14:0];
    end
  end

  // Matrix entries ride alongside the square root chain.
  logic [111:0] dly [SS];
  rme_pkg::sqrt_t sq [SS+1];
  logic signed [15:0] sp_in;
  logic signed [15:0] raw;
  logic [14:0] sp_mag;
  logic [28:0] one_minus;
  logic [rme_pkg::RadW-1:0] rad;
  assign raw = s_tdata[47:32];
  always_comb begin
    sp_in = raw;
    if (raw > 16'sd16384) sp_in = 16'sd16384;
    if (raw < -16'sd16384) sp_in = -16'sd16384;
    sp_mag = sp_in[15] ? 15'(-sp_in) : sp_in[14:0];
    one_minus = 29'h1000_0000 - 29'(sp_mag) * 29'(sp_mag);
    rad = {one_minus, 16'd0};
    sq[0].rem = rad;
    sq[0].res = '0;
    sq[0].bitv = {1'b1, 44'd0};
    sq[0].sp = sp_in;
  end

  genvar g;
  generate
    for (g = 0; g < SS; g++) begin : g_sq
      rme_sqrt_cell u_c (.clk(clk), .en(en), .din(sq[g]), .dout(sq[g+1]));
      always_ff @(posedge clk) begin
        if (en) dly[g] <= (g == 0) ? s_tdata : dly[(g == 0) ? 0 : g-1];
      end
    end
  endgenerate

  // Pre-rotation stage: lane 0 pitch, lane 1 yaw, lane 2 roll.
  rme_pkg::vec_t cv [3][CS+1];
  logic lock_p [CS+1];
  logic signed [15:0] m00, m01, m10, m11, m12, m22;
  logic [23:0] cp;
  logic lk;
  assign m00 = dly[SS-1][15:0];
  assign m01 = dly[SS-1][31:16];
  assign m10 = dly[SS-1][63:48];
  assign m11 = dly[SS-1][79:64];
  assign m12 = dly[SS-1][95:80];
  assign m22 = dly[SS-1][111:96];
  assign cp = sq[SS].res[23:0];
  assign lk = {8'd0, cp} <= {9'd0, lock_threshold, 8'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      if (sq[SS].sp == 0 && cp == 0) cv[0][0] <= '0;
      else cv[0][0] <= rme_pkg::pre_rot(34'(sq[SS].sp) <<< 15, 34'(cp) <<< 7);
      if (lk) begin
        if (m10 == 0 && m11 == 0) cv[1][0] <= '0;
        else cv[1][0] <= rme_pkg::pre_rot(34'(m10) <<< 14, 34'(m11) <<< 14);
      end else begin
        if (m00 == 0 && m01 == 0) cv[1][0] <= '0;
        else cv[1][0] <= rme_pkg::pre_rot(34'(m01) <<< 14, 34'(m00) <<< 14);
      end
      if (m12 == 0 && m22 == 0) cv[2][0] <= '0;
      else cv[2][0] <= rme_pkg::pre_rot(34'(m12) <<< 14, 34'(m22) <<< 14);
      lock_p[0] <= lk;
    end
  end

  genvar l;
  generate
    for (g = 0; g < CS; g++) begin : g_cd
      for (l = 0; l < 3; l++) begin : g_ln
        rme_cordic_cell u_c (.clk(clk), .en(en), .step(5'(g)),
                             .din(cv[l][g]), .dout(cv[l][g+1]));
      end
      always_ff @(posedge clk) begin
        if (en) lock_p[g+1] <= lock_p[g];
      end
    end
  endgenerate

  // Note: an all-zero operand pair still iterates; x=y=0 stays 0 but z moves.
  // Zero pairs are flagged so the angle is forced to zero.
  logic zf [3][CS+1];
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0][0] <= sq[SS].sp == 0 && cp == 0;
      zf[1][0] <= lk ? (m10 == 0 && m11 == 0) : (m00 == 0 && m01 == 0);
      zf[2][0] <= m12 == 0 && m22 == 0;
    end
  end
  generate
    for (g = 0; g < CS; g++) begin : g_zf
      always_ff @(posedge clk) begin
        if (en) begin
          zf[0][g+1] <= zf[0][g];
          zf[1][g+1] <= zf[1][g];
          zf[2][g+1] <= zf[2][g];
        end
      end
    end
  endgenerate

  logic signed [15:0] p_o, y_o, r_o;
  logic signed [15:0] p_n, y_n, r_n;
  always_comb begin
    p_n = zf[0][CS] ? 16'sd0 : -rme_pkg::to_out(cv[0][CS].z, rme_pkg::PitchLimit);
    y_n = zf[1][CS] ? 16'sd0 : rme_pkg::to_out(cv[1][CS].z, rme_pkg::YawLimit);
    if (lock_p[CS]) y_n = -y_n;
    r_n = (lock_p[CS] || zf[2][CS]) ? 16'sd0 :
          rme_pkg::to_out(cv[2][CS].z, rme_pkg::YawLimit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], s_tvalid};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p_o <= p_n;
      y_o <= y_n;
      r_o <= r_n;
      m_tuser <= lock_p[CS];
    end
  end
  assign m_tvalid = vld[L-1];
  assign m_tdata = {1'b0, r_o, y_o, p_o[14:0]};
endmodule
`default_nettype wire

>>> rtl/core/rme_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rme_sqrt_cell
// One step of the restoring square root, registered.
// ----------------------------------------------------------------------------
module rme_sqrt_cell (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire rme_pkg::sqrt_t din,
  output rme_pkg::sqrt_t     dout
);
  rme_pkg::sqrt_t q;
  always_comb begin
    q = din;
    if (din.bitv != '0) begin
      if (din.rem >= din.res + din.bitv) begin
        q.rem = din.rem - (din.res + din.bitv);
        q.res = (din.res >> 1) + din.bitv;
      end else begin
        q.res = din.res >> 1;
      end
      q.bitv = din.bitv >> 2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dout <= q;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/rme_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rme_cordic_cell
// One vectoring step for one angle lane, registered.
// ----------------------------------------------------------------------------
module rme_cordic_cell (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [4:0]    step,
  input  wire rme_pkg::vec_t din,
  output rme_pkg::vec_t      dout
);
  rme_pkg::vec_t q;
  always_comb begin
    q = din;
    if (din.y >= 0) begin
      q.x = din.x + (din.y >>> step);
      q.y = din.y - (din.x >>> step);
      q.z = din.z + rme_pkg::atan_tab(int'(step));
    end else begin
      q.x = din.x - (din.y >>> step);
      q.y = din.y + (din.x >>> step);
      q.z = din.z - rme_pkg::atan_tab(int'(step));
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dout <= q;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/rme_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rme_checker
// Port-level checks for the Euler angle block.
// ----------------------------------------------------------------------------
module rme_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        pready
);
  a_roll_lock: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[46:31] == 16'd0) else $error("roll in lock");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[47]) else $error("pad bit set");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
  a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
endmodule
bind rotation_matrix_to_euler_top rme_checker u_chk (.*);
`default_nettype wire
